// ===== hdl/omi_pkg.sv =====
// Shared constants and types for the occupancy map inflation block.
package omi_pkg;

    localparam int CELL_W = 8;
    localparam int DIM_W = 9;
    localparam int RAD_W = 4;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_MAP_WIDTH = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;
    localparam logic [1:0] REG_THRESHOLD = 2'd3;

    localparam logic [DIM_W-1:0] RST_MAP_WIDTH = 9'd256;
    localparam logic [DIM_W-1:0] RST_MAP_HEIGHT = 9'd256;
    localparam logic [RAD_W-1:0] RST_RADIUS = 4'd1;
    localparam logic signed [CELL_W-1:0] RST_THRESHOLD = 8'sd55;

    localparam logic signed [CELL_W-1:0] OBSTACLE_MARK = 8'sd100;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic valid;
        logic center;
        logic last;
    } rd_tag_t;

endpackage

// ===== hdl/occupancy_map_inflation_top.sv =====
// Occupancy grid store with square-window obstacle inflation on reads.
// Write transaction: stored in the accept cycle, no result; ready again in the next cycle.
// Read transaction: center cell read in SETUP, then the window x0..x1, y0..y1 scanned in SCAN
// through the single read port of the grid memory, one cell per cycle, then DRAIN and DONE.
// Out-of-map read: SETUP goes straight to DONE. Reset (aresetn low, synchronous) clears
// control and registers to defaults; grid contents stay undefined until written.
module occupancy_map_inflation_top #(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int RADIUS_CAP = 15
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // APB configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [omi_pkg::PADDR_W-1:0]      paddr,
    input  logic [omi_pkg::PDATA_W-1:0]      pwdata,
    output logic [omi_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [23:0]                      s_axis_tdata,  // cell_x, cell_y, cell_value
    input  logic                             s_axis_tuser,  // mode
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,  // inflated_value
    output logic                             m_axis_tuser   // out_of_range
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW = omi_pkg::DIM_W;
    localparam int RW = omi_pkg::RAD_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    function automatic logic [AW-1:0] cell_addr(input logic [DW-1:0] x, input logic [DW-1:0] y);
        cell_addr = AW'(int'(y) * MAX_WIDTH + int'(x));
    endfunction

    // configuration registers
    logic [DW-1:0]        map_width_reg;
    logic [DW-1:0]        map_height_reg;
    logic [RW-1:0]        radius_reg;
    logic signed [7:0]    thr_reg;

    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg <= omi_pkg::RST_MAP_WIDTH;
            map_height_reg <= omi_pkg::RST_MAP_HEIGHT;
            radius_reg <= omi_pkg::RST_RADIUS;
            thr_reg <= omi_pkg::RST_THRESHOLD;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                omi_pkg::REG_MAP_WIDTH: map_width_reg <= pwdata[DW-1:0];
                omi_pkg::REG_MAP_HEIGHT: map_height_reg <= pwdata[DW-1:0];
                omi_pkg::REG_RADIUS: radius_reg <= pwdata[RW-1:0];
                omi_pkg::REG_THRESHOLD: thr_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            omi_pkg::REG_MAP_WIDTH: prdata = 32'(map_width_reg);
            omi_pkg::REG_MAP_HEIGHT: prdata = 32'(map_height_reg);
            omi_pkg::REG_RADIUS: prdata = 32'(radius_reg);
            omi_pkg::REG_THRESHOLD: prdata = {24'd0, thr_reg};
            default: prdata = '0;
        endcase
    end

    // effective dimensions and radius
    logic [DW-1:0] eff_w;
    logic [DW-1:0] eff_h;
    logic [RW-1:0] eff_r;

    always_comb begin
        if (map_width_reg == '0) begin
            eff_w = DW'(1);
        end else if (13'(map_width_reg) > 13'(MAX_WIDTH)) begin
            eff_w = DW'(MAX_WIDTH);
        end else begin
            eff_w = map_width_reg;
        end
        if (map_height_reg == '0) begin
            eff_h = DW'(1);
        end else if (13'(map_height_reg) > 13'(MAX_HEIGHT)) begin
            eff_h = DW'(MAX_HEIGHT);
        end else begin
            eff_h = map_height_reg;
        end
        if (7'(radius_reg) > 7'(RADIUS_CAP)) begin
            eff_r = RW'(RADIUS_CAP);
        end else begin
            eff_r = radius_reg;
        end
    end

    // input unpacking
    logic                 in_mode;
    logic [DW-1:0]        in_x;
    logic [DW-1:0]        in_y;
    logic [7:0]           in_value;
    logic                 in_accept;
    logic                 in_inside;

    assign in_mode = s_axis_tuser;
    assign in_x = {1'b0, s_axis_tdata[7:0]};
    assign in_y = {1'b0, s_axis_tdata[15:8]};
    assign in_value = s_axis_tdata[23:16];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_inside = (in_x < eff_w) && (in_y < eff_h);

    // control state
    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [DW-1:0]        cx_reg;
    logic [DW-1:0]        cy_reg;
    logic [DW-1:0]        x0_reg;
    logic [DW-1:0]        x1_reg;
    logic [DW-1:0]        y1_reg;
    logic [DW-1:0]        y0_reg;
    logic [DW-1:0]        xs_reg;
    logic [DW-1:0]        ys_reg;
    logic                 hit_reg;
    logic [7:0]           center_reg;
    logic [7:0]           res_val_reg;
    logic                 res_oor_reg;
    omi_pkg::rd_tag_t     tag_reg;
    omi_pkg::rd_tag_t     tag_next;

    logic                 m_valid_reg;
    logic [7:0]           m_data_reg;
    logic                 m_user_reg;
    logic                 out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata = m_data_reg;
    assign m_axis_tuser = m_user_reg;

    // window bounds
    logic          c_inside;
    logic [DW-1:0] sum_x;
    logic [DW-1:0] sum_y;
    logic [DW-1:0] bx0;
    logic [DW-1:0] bx1;
    logic [DW-1:0] by0;
    logic [DW-1:0] by1;
    logic          scan_last;

    always_comb begin
        c_inside = (cx_reg < eff_w) && (cy_reg < eff_h);
        sum_x = cx_reg + DW'(eff_r);
        sum_y = cy_reg + DW'(eff_r);
        bx0 = (cx_reg >= DW'(eff_r)) ? cx_reg - DW'(eff_r) : '0;
        by0 = (cy_reg >= DW'(eff_r)) ? cy_reg - DW'(eff_r) : '0;
        bx1 = (sum_x < eff_w) ? sum_x : eff_w - DW'(1);
        by1 = (sum_y < eff_h) ? sum_y : eff_h - DW'(1);
        scan_last = (xs_reg == x1_reg) && (ys_reg == y1_reg);
    end

    // grid memory
    logic [7:0]    grid_mem [DEPTH];
    logic [7:0]    rdata_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign wr_en = in_accept && (in_mode == omi_pkg::MODE_WRITE) && in_inside;
    assign wr_addr = cell_addr(in_x, in_y);
    assign rd_addr = (state_reg == ST_SETUP) ? cell_addr(cx_reg, cy_reg)
                                             : cell_addr(xs_reg, ys_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            grid_mem[wr_addr] <= in_value;
        end
        rdata_reg <= grid_mem[rd_addr];
    end

    logic obstacle;
    assign obstacle = $signed(rdata_reg) > thr_reg;

    always_comb begin
        tag_next.valid = ((state_reg == ST_SETUP) && c_inside) || (state_reg == ST_SCAN);
        tag_next.center = (state_reg == ST_SETUP);
        tag_next.last = (state_reg == ST_SCAN) && scan_last;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_accept && in_mode == omi_pkg::MODE_READ) state_next = ST_SETUP;
            ST_SETUP: state_next = c_inside ? ST_SCAN : ST_DONE;
            ST_SCAN:  if (scan_last) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tag_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            tag_reg <= tag_next;
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            cx_reg <= in_x;
            cy_reg <= in_y;
        end
        if (state_reg == ST_SETUP) begin
            x0_reg <= bx0;
            x1_reg <= bx1;
            y0_reg <= by0;
            y1_reg <= by1;
            xs_reg <= bx0;
            ys_reg <= by0;
            hit_reg <= 1'b0;
            res_val_reg <= '0;
            res_oor_reg <= !c_inside;
        end else if (state_reg == ST_SCAN) begin
            if (xs_reg == x1_reg) begin
                xs_reg <= x0_reg;
                ys_reg <= ys_reg + DW'(1);
            end else begin
                xs_reg <= xs_reg + DW'(1);
            end
        end
        if (tag_reg.valid) begin
            if (tag_reg.center) begin
                center_reg <= rdata_reg;
            end else if (obstacle) begin
                hit_reg <= 1'b1;
            end
        end
        if (state_reg == ST_DRAIN) begin
            res_val_reg <= (hit_reg || obstacle) ? omi_pkg::OBSTACLE_MARK : center_reg;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg <= res_val_reg;
            m_user_reg <= res_oor_reg;
        end
    end

    a_last_to_done: assert property (@(posedge aclk) disable iff (!aresetn)
        tag_reg.last |-> state_reg == ST_DRAIN)
        else $error("last scan read not matched with drain");

    a_scan_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> xs_reg >= x0_reg && xs_reg <= x1_reg
                                 && ys_reg >= y0_reg && ys_reg <= y1_reg)
        else $error("scan position outside window");

    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> state_reg == ST_IDLE)
        else $error("grid write while a read is in progress");

    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> m_valid_reg && state_reg == ST_IDLE)
        else $error("result not presented after completion");

endmodule
